@@ rtl/lav_pkg.sv @@
`timescale 1ns / 1ps

package lav_pkg;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 16;

    localparam logic [COORD_W-1:0] SAT_HI = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_LO = 32'h8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] eye_x;
        logic signed [COORD_W-1:0] eye_y;
        logic signed [COORD_W-1:0] eye_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic signed [COORD_W-1:0] up_hint_x;
        logic signed [COORD_W-1:0] up_hint_y;
        logic signed [COORD_W-1:0] up_hint_z;
    } lav_setup_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] side_x;
        logic signed [ENTRY_W-1:0] side_y;
        logic signed [ENTRY_W-1:0] side_z;
        logic signed [ENTRY_W-1:0] true_up_x;
        logic signed [ENTRY_W-1:0] true_up_y;
        logic signed [ENTRY_W-1:0] true_up_z;
        logic signed [ENTRY_W-1:0] back_x;
        logic signed [ENTRY_W-1:0] back_y;
        logic signed [ENTRY_W-1:0] back_z;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [COORD_W-1:0] shift_z;
    } lav_view_t;

endpackage

@@ rtl/lav_unitize.sv @@
`timescale 1ns / 1ps

// Pipelined 3-vector normalizer: magnitude, leading-one normalize to 31 bits,
// squares, 32-step square root, UNIT_FRAC_BITS+1 step divide, sign restore.
module lav_unitize #(
    parameter int IW = 33,
    parameter int UNIT_FRAC_BITS = 14,
    parameter int TAG_W = 1,
    localparam int OW = UNIT_FRAC_BITS + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 valid,
    input  logic signed [IW-1:0] vec [3],
    input  logic [TAG_W-1:0]     tag_in,
    output logic                 unit_valid,
    output logic signed [OW-1:0] unit [3],
    output logic [TAG_W-1:0]     tag_out
);
    import lav_pkg::*;

    localparam int NW  = (IW > 31) ? IW : 31;
    localparam int SH  = $clog2(NW);
    localparam int RT  = 32;
    localparam int QB  = UNIT_FRAC_BITS + 1;
    localparam int NB  = 32 + UNIT_FRAC_BITS;
    localparam int LAT = SH + QB + 37;

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [TAG_W-1:0] tag;
    } side_t;

    logic [LAT-1:0]      vld_reg;
    side_t               side_reg [LAT];
    logic [NW-1:0]       mag [3];
    logic [NW-1:0]       nm_reg [SH+1][3];
    logic [30:0]         top [3];
    logic [61:0]         sq_reg [3];
    logic [30:0]         sqa_reg [3];
    logic [33:0]         rt_rem [RT];
    logic [63:0]         rt_v [RT];
    logic [31:0]         rt_root [RT+1];
    logic [30:0]         rt_a [RT+1][3];
    logic [NB-1:0]       num [3];
    logic [31:0]         dv_rem [QB][3];
    logic [QB-1:0]       dv_lq [QB+1][3];
    logic [31:0]         dv_l [QB];
    logic signed [OW-1:0] unit_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], valid};
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            mag[j] = vec[j][IW-1] ? NW'($unsigned(-vec[j])) : NW'($unsigned(vec[j]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].zero <= (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
            side_reg[0].neg  <= {vec[2][IW-1], vec[1][IW-1], vec[0][IW-1]};
            side_reg[0].tag  <= tag_in;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            nm_reg[0] <= mag;
        end
    end

    // shift all three left together until the common top bit sits at NW-1
    for (genvar i = 1; i <= SH; i++)
    begin : g_norm
        localparam int A = 1 << (SH - i);
        logic [NW-1:0] orv;
        assign orv = nm_reg[i-1][0] | nm_reg[i-1][1] | nm_reg[i-1][2];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    nm_reg[i][j] <= (orv[NW-1 -: A] == '0) ? (nm_reg[i-1][j] << A)
                                                           : nm_reg[i-1][j];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            top[j] = nm_reg[SH][j][NW-1 -: 31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j]  <= 62'(top[j]) * 62'(top[j]);
                sqa_reg[j] <= top[j];
            end
            rt_v[0]    <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            rt_rem[0]  <= '0;
            rt_root[0] <= '0;
            rt_a[0]    <= sqa_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 1; k <= RT; k++)
    begin : g_root
        logic [35:0] r2;
        logic [35:0] trial;
        logic        fit;
        assign r2    = {rt_rem[k-1], rt_v[k-1][63:62]};
        assign trial = {2'b00, rt_root[k-1], 2'b01};
        assign fit   = (r2 >= trial);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_root[k] <= {rt_root[k-1][30:0], fit};
                rt_a[k]    <= rt_a[k-1];
            end
        end
        if (k < RT)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rt_rem[k] <= fit ? 34'(r2 - trial) : r2[33:0];
                    rt_v[k]   <= rt_v[k-1] << 2;
                end
            end
        end
    end

    // numerator with half the divisor added for round half up
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            num[j] = NB'({rt_a[RT][j], {UNIT_FRAC_BITS{1'b0}}}) + NB'(rt_root[RT] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dv_rem[0][j] <= 32'(num[j][NB-1 -: 31]);
                dv_lq[0][j]  <= num[j][QB-1:0];
            end
            dv_l[0] <= rt_root[RT];
        end
    end

    // one quotient bit per stage; low numerator bits shift out as quotient shifts in
    for (genvar d = 1; d <= QB; d++)
    begin : g_div
        logic [32:0] t [3];
        logic        fit [3];
        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                t[j]   = {dv_rem[d-1][j], dv_lq[d-1][j][QB-1]};
                fit[j] = (t[j] >= {1'b0, dv_l[d-1]});
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dv_lq[d][j] <= {dv_lq[d-1][j][QB-2:0], fit[j]};
                end
            end
        end
        if (d < QB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        dv_rem[d][j] <= fit[j] ? 32'(t[j] - {1'b0, dv_l[d-1]}) : t[j][31:0];
                    end
                    dv_l[d] <= dv_l[d-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (side_reg[LAT-2].zero)
                begin
                    unit_reg[j] <= '0;
                end
                else if (side_reg[LAT-2].neg[j])
                begin
                    unit_reg[j] <= -OW'(dv_lq[QB][j]);
                end
                else
                begin
                    unit_reg[j] <= OW'(dv_lq[QB][j]);
                end
            end
        end
    end

    assign unit       = unit_reg;
    assign tag_out    = side_reg[LAT-1].tag;
    assign unit_valid = vld_reg[LAT-1];

endmodule

@@ rtl/look_at_view_matrix.sv @@
`timescale 1ns / 1ps

// channel   dir  valid        stall        payload
// setup     in   setup_valid  setup_stall  lav_setup_t  eye, target, up hint (Q16.16)
// view      out  view_valid   view_stall   lav_view_t   rows (Q2.14), shifts (Q16.16)
//
// One beat per cycle while no stalled view beat holds the pipeline. Its depth is
// set by the two normalizers in series, each a 32-stage root pipeline
// followed by a UNIT_FRAC_BITS+1 stage divider.
// rst_n clears valid bits only. A stalled view beat freezes the whole pipeline.
module look_at_view_matrix #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                setup_valid,
    output logic                setup_stall,
    input  lav_pkg::lav_setup_t setup,
    output logic                view_valid,
    input  logic                view_stall,
    output lav_pkg::lav_view_t  view
);
    import lav_pkg::*;

    localparam int U  = UNIT_FRAC_BITS;
    localparam int OW = U + 2;
    localparam int PW = 2 * OW;
    localparam int CW = PW + 1;
    localparam int EW = OW + COORD_W;
    localparam int DW = EW + 2;
    localparam int FW = COORD_W + 1;
    localparam int TW = 3 * OW + 3 * COORD_W;

    localparam logic [CW-1:0] HALF_C = CW'(1) << (U - 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1) << U;
    localparam logic [DW-1:0] HALF_D = DW'(1) << (U - 1);

    function automatic logic signed [OW-1:0] round_unit(input logic signed [CW-1:0] x);
        logic [CW-1:0] m;
        logic [CW-1:0] r;
        m = x[CW-1] ? $unsigned(-x) : $unsigned(x);
        r = (m + HALF_C) >> U;
        if (r > ONE_C)
        begin
            r = ONE_C;
        end
        return x[CW-1] ? -OW'(r) : OW'(r);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_shift(input logic signed [DW-1:0] x,
                                                            input logic negate);
        logic [DW-1:0] m;
        logic [DW-1:0] r;
        logic [DW-1:0] nr;
        logic          neg;
        m   = x[DW-1] ? $unsigned(-x) : $unsigned(x);
        r   = (m + HALF_D) >> U;
        nr  = -r;
        neg = x[DW-1] ^ negate;
        if (!neg)
        begin
            return (r > DW'(SAT_HI)) ? SAT_HI : r[COORD_W-1:0];
        end
        return (r > DW'(SAT_LO)) ? SAT_LO : nr[COORD_W-1:0];
    endfunction

    function automatic logic [ENTRY_W-1:0] to_entry(input logic signed [OW-1:0] v);
        logic signed [OW+ENTRY_W-1:0] e;
        e = (OW + ENTRY_W)'(v);
        return e[ENTRY_W-1:0];
    endfunction

    logic                adv;
    lav_setup_t          setup_reg;
    logic                s0_vld_reg;
    logic signed [FW-1:0] fwd [3];
    logic signed [FW-1:0] upv [3];

    logic                f_vld, up_vld, s_vld;
    logic signed [OW-1:0] f_u [3];
    logic signed [OW-1:0] up_u [3];
    logic signed [OW-1:0] s_u [3];
    logic [2*COORD_W-1:0] f_tag;
    logic [COORD_W-1:0]   up_tag;
    logic [TW-1:0]        s_tag_in, s_tag;

    logic                 c1_vld_reg, c2_vld_reg;
    logic signed [PW-1:0] c1_p_reg [6];
    logic signed [OW-1:0] c1_f_reg [3];
    logic signed [COORD_W-1:0] c1_eye_reg [3];
    logic signed [CW-1:0] c2_s_reg [3];
    logic signed [OW-1:0] c2_f_reg [3];
    logic signed [COORD_W-1:0] c2_eye_reg [3];

    logic signed [OW-1:0] sf [3];
    logic signed [COORD_W-1:0] se [3];

    logic                 t1_vld_reg, t2_vld_reg, t3_vld_reg, t4_vld_reg, t5_vld_reg;
    logic signed [PW-1:0] t1_p_reg [6];
    logic signed [EW-1:0] t1_se_reg [3];
    logic signed [EW-1:0] t1_fe_reg [3];
    logic signed [OW-1:0] t1_s_reg [3];
    logic signed [OW-1:0] t1_f_reg [3];
    logic signed [COORD_W-1:0] t1_eye_reg [3];
    logic signed [CW-1:0] t2_u_reg [3];
    logic signed [DW-1:0] t2_ds_reg, t2_df_reg;
    logic signed [OW-1:0] t2_s_reg [3];
    logic signed [OW-1:0] t2_f_reg [3];
    logic signed [COORD_W-1:0] t2_eye_reg [3];
    logic signed [OW-1:0] t3_u_reg [3];
    logic signed [COORD_W-1:0] t3_sx_reg, t3_sz_reg;
    logic signed [OW-1:0] t3_s_reg [3];
    logic signed [OW-1:0] t3_f_reg [3];
    logic signed [COORD_W-1:0] t3_eye_reg [3];
    logic signed [EW-1:0] t4_ue_reg [3];
    logic signed [OW-1:0] t4_u_reg [3];
    logic signed [OW-1:0] t4_s_reg [3];
    logic signed [OW-1:0] t4_f_reg [3];
    logic signed [COORD_W-1:0] t4_sx_reg, t4_sz_reg;
    logic signed [DW-1:0] t5_du_reg;
    logic signed [OW-1:0] t5_u_reg [3];
    logic signed [OW-1:0] t5_s_reg [3];
    logic signed [OW-1:0] t5_f_reg [3];
    logic signed [COORD_W-1:0] t5_sx_reg, t5_sz_reg;

    logic                 view_valid_reg;
    lav_view_t            view_reg;

    assign adv         = !(view_valid_reg && view_stall);
    assign setup_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg     <= 1'b0;
            c1_vld_reg     <= 1'b0;
            c2_vld_reg     <= 1'b0;
            t1_vld_reg     <= 1'b0;
            t2_vld_reg     <= 1'b0;
            t3_vld_reg     <= 1'b0;
            t4_vld_reg     <= 1'b0;
            t5_vld_reg     <= 1'b0;
            view_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg     <= setup_valid;
            c1_vld_reg     <= f_vld && up_vld;
            c2_vld_reg     <= c1_vld_reg;
            t1_vld_reg     <= s_vld;
            t2_vld_reg     <= t1_vld_reg;
            t3_vld_reg     <= t2_vld_reg;
            t4_vld_reg     <= t3_vld_reg;
            t5_vld_reg     <= t4_vld_reg;
            view_valid_reg <= t5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            setup_reg <= setup;
        end
    end

    assign fwd[0] = FW'(setup_reg.target_x) - FW'(setup_reg.eye_x);
    assign fwd[1] = FW'(setup_reg.target_y) - FW'(setup_reg.eye_y);
    assign fwd[2] = FW'(setup_reg.target_z) - FW'(setup_reg.eye_z);
    assign upv[0] = FW'(setup_reg.up_hint_x);
    assign upv[1] = FW'(setup_reg.up_hint_y);
    assign upv[2] = FW'(setup_reg.up_hint_z);

    lav_unitize #(
        .IW             (FW),
        .UNIT_FRAC_BITS (U),
        .TAG_W          (2 * COORD_W)
    ) u_fwd (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid      (s0_vld_reg),
        .vec        (fwd),
        .tag_in     ({setup_reg.eye_x, setup_reg.eye_y}),
        .unit_valid (f_vld),
        .unit       (f_u),
        .tag_out    (f_tag)
    );

    lav_unitize #(
        .IW             (FW),
        .UNIT_FRAC_BITS (U),
        .TAG_W          (COORD_W)
    ) u_up (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid      (s0_vld_reg),
        .vec        (upv),
        .tag_in     (setup_reg.eye_z),
        .unit_valid (up_vld),
        .unit       (up_u),
        .tag_out    (up_tag)
    );

    // side = forward x up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_p_reg[0]   <= f_u[1] * up_u[2];
            c1_p_reg[1]   <= f_u[2] * up_u[1];
            c1_p_reg[2]   <= f_u[2] * up_u[0];
            c1_p_reg[3]   <= f_u[0] * up_u[2];
            c1_p_reg[4]   <= f_u[0] * up_u[1];
            c1_p_reg[5]   <= f_u[1] * up_u[0];
            c1_f_reg      <= f_u;
            c1_eye_reg[0] <= $signed(f_tag[2*COORD_W-1 -: COORD_W]);
            c1_eye_reg[1] <= $signed(f_tag[COORD_W-1:0]);
            c1_eye_reg[2] <= $signed(up_tag);
            for (int j = 0; j < 3; j++)
            begin
                c2_s_reg[j] <= CW'(c1_p_reg[2*j]) - CW'(c1_p_reg[2*j+1]);
            end
            c2_f_reg   <= c1_f_reg;
            c2_eye_reg <= c1_eye_reg;
        end
    end

    assign s_tag_in = {c2_f_reg[0], c2_f_reg[1], c2_f_reg[2],
                       c2_eye_reg[0], c2_eye_reg[1], c2_eye_reg[2]};

    lav_unitize #(
        .IW             (CW),
        .UNIT_FRAC_BITS (U),
        .TAG_W          (TW)
    ) u_side (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid      (c2_vld_reg),
        .vec        (c2_s_reg),
        .tag_in     (s_tag_in),
        .unit_valid (s_vld),
        .unit       (s_u),
        .tag_out    (s_tag)
    );

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sf[j] = $signed(s_tag[3*COORD_W + (2-j)*OW +: OW]);
            se[j] = $signed(s_tag[(2-j)*COORD_W +: COORD_W]);
        end
    end

    // true up = side x forward, plus the translation dot products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_p_reg[0] <= s_u[1] * sf[2];
            t1_p_reg[1] <= s_u[2] * sf[1];
            t1_p_reg[2] <= s_u[2] * sf[0];
            t1_p_reg[3] <= s_u[0] * sf[2];
            t1_p_reg[4] <= s_u[0] * sf[1];
            t1_p_reg[5] <= s_u[1] * sf[0];
            for (int j = 0; j < 3; j++)
            begin
                t1_se_reg[j] <= s_u[j] * se[j];
                t1_fe_reg[j] <= sf[j] * se[j];
            end
            t1_s_reg   <= s_u;
            t1_f_reg   <= sf;
            t1_eye_reg <= se;

            for (int j = 0; j < 3; j++)
            begin
                t2_u_reg[j] <= CW'(t1_p_reg[2*j]) - CW'(t1_p_reg[2*j+1]);
            end
            t2_ds_reg  <= DW'(t1_se_reg[0]) + DW'(t1_se_reg[1]) + DW'(t1_se_reg[2]);
            t2_df_reg  <= DW'(t1_fe_reg[0]) + DW'(t1_fe_reg[1]) + DW'(t1_fe_reg[2]);
            t2_s_reg   <= t1_s_reg;
            t2_f_reg   <= t1_f_reg;
            t2_eye_reg <= t1_eye_reg;

            for (int j = 0; j < 3; j++)
            begin
                t3_u_reg[j] <= round_unit(t2_u_reg[j]);
            end
            t3_sx_reg  <= sat_shift(t2_ds_reg, 1'b1);
            t3_sz_reg  <= sat_shift(t2_df_reg, 1'b0);
            t3_s_reg   <= t2_s_reg;
            t3_f_reg   <= t2_f_reg;
            t3_eye_reg <= t2_eye_reg;

            for (int j = 0; j < 3; j++)
            begin
                t4_ue_reg[j] <= t3_u_reg[j] * t3_eye_reg[j];
            end
            t4_u_reg  <= t3_u_reg;
            t4_s_reg  <= t3_s_reg;
            t4_f_reg  <= t3_f_reg;
            t4_sx_reg <= t3_sx_reg;
            t4_sz_reg <= t3_sz_reg;

            t5_du_reg <= DW'(t4_ue_reg[0]) + DW'(t4_ue_reg[1]) + DW'(t4_ue_reg[2]);
            t5_u_reg  <= t4_u_reg;
            t5_s_reg  <= t4_s_reg;
            t5_f_reg  <= t4_f_reg;
            t5_sx_reg <= t4_sx_reg;
            t5_sz_reg <= t4_sz_reg;

            view_reg.side_x    <= to_entry(t5_s_reg[0]);
            view_reg.side_y    <= to_entry(t5_s_reg[1]);
            view_reg.side_z    <= to_entry(t5_s_reg[2]);
            view_reg.true_up_x <= to_entry(t5_u_reg[0]);
            view_reg.true_up_y <= to_entry(t5_u_reg[1]);
            view_reg.true_up_z <= to_entry(t5_u_reg[2]);
            view_reg.back_x    <= to_entry(-t5_f_reg[0]);
            view_reg.back_y    <= to_entry(-t5_f_reg[1]);
            view_reg.back_z    <= to_entry(-t5_f_reg[2]);
            view_reg.shift_x   <= t5_sx_reg;
            view_reg.shift_y   <= sat_shift(t5_du_reg, 1'b1);
            view_reg.shift_z   <= t5_sz_reg;
        end
    end

    assign view_valid = view_valid_reg;
    assign view       = view_reg;

endmodule
